[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. With SYNTH defined they
// expand to nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication in the same cycle.
`define MTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication into the following cycle.
`define MTU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MTU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/mtu_pkg.sv]
// ---------------------------------------------------------------------------
// mtu_pkg
// Operation codes, status codes and widths for the multi-turn unwrapper.
// ---------------------------------------------------------------------------
package mtu_pkg;

  // Width used for all single-turn arithmetic; holds values below 3 * 65536.
  localparam int SW = 18;

  localparam int RAW_MODULUS_DEF = 16384;

  typedef logic [1:0] func_t;
  typedef logic [2:0] status_t;

  localparam func_t FUNC_UPDATE = 2'd0;
  localparam func_t FUNC_BIND   = 2'd1;
  localparam func_t FUNC_UNBIND = 2'd2;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_RANGE     = 3'd1;
  localparam status_t ST_WINDOW    = 3'd2;
  localparam status_t ST_AMBIGUOUS = 3'd3;
  localparam status_t ST_FAR       = 3'd4;
  localparam status_t ST_OVERFLOW  = 3'd5;

endpackage

[rtl/core/multiturn_encoder_unwrapper.sv]
// ---------------------------------------------------------------------------
// multiturn_encoder_unwrapper
// Tracks a signed 32-bit multi-turn position from single-turn encoder words,
// with bind to a reference, unbind and half-turn wrapped updates.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | func, sample_raw, reference_position,
//          |           |                       | bind_window
//  out_    | output    | out_valid / out_ready | status, position, is_bound
//
// One word per cycle is accepted while the output side takes results; each
// result passes in order through the input register, reciprocal multiply,
// turn-remainder reduction, then the result register.
// The tracker state is read and written only at the result stage, so a word
// sees everything its predecessors left. Reset is synchronous, active low.
// When the output word is stalled the whole pipeline holds and in_ready falls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multiturn_encoder_unwrapper #(
  parameter int RAW_MODULUS = mtu_pkg::RAW_MODULUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [15:0]           in_sample_raw,
  input  logic signed [31:0]    in_reference_position,
  input  logic [15:0]           in_bind_window,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic signed [31:0]    out_position,
  output logic                  out_is_bound
);

  localparam int SW = mtu_pkg::SW;

  // Reciprocal of the modulus; the quotient it gives is at most one short.
  localparam logic [31:0]   RECIP  = 32'((64'd1 << 32) / 64'(RAW_MODULUS));
  localparam logic [63:0]   OFF    = (64'd1 << 31) % 64'(RAW_MODULUS);
  localparam logic [SW-1:0] K_S    = SW'((64'(RAW_MODULUS) - OFF) % 64'(RAW_MODULUS));
  localparam logic [SW-1:0] MOD_S  = SW'(RAW_MODULUS);
  localparam logic [SW-1:0] MOD2_S = SW'(2 * RAW_MODULUS);
  localparam logic signed [SW-1:0] MODS_S  = SW'(RAW_MODULUS);
  localparam logic signed [SW-1:0] HALF_S  = SW'(RAW_MODULUS / 2);
  localparam logic signed [SW-1:0] NHALF_S = -SW'(RAW_MODULUS / 2);

  logic adv;

  // Stage 1: input register.
  logic                 s1_v_r;
  mtu_pkg::func_t       s1_func_r;
  logic [15:0]          s1_raw_r;
  logic signed [31:0]   s1_ref_r;
  logic [15:0]          s1_win_r;

  // Stage 2: low bits of the quotient of the offset reference.
  logic                 s2_v_r;
  mtu_pkg::func_t       s2_func_r;
  logic [15:0]          s2_raw_r;
  logic signed [31:0]   s2_ref_r;
  logic [15:0]          s2_win_r;
  logic [SW-1:0]        s2_q_r;

  // Stage 3: reference modulo the turn, in [0, modulus).
  logic                 s3_v_r;
  mtu_pkg::func_t       s3_func_r;
  logic [15:0]          s3_raw_r;
  logic signed [31:0]   s3_ref_r;
  logic [15:0]          s3_win_r;
  logic [SW-1:0]        s3_a_r;

  // Tracker state.
  logic                 bound_r, bound_nxt;
  logic [15:0]          last_r, last_nxt;
  logic signed [31:0]   pos_r, pos_nxt;

  // Result register.
  logic                 out_valid_r;
  mtu_pkg::status_t     out_status_r, status_nxt;
  logic signed [31:0]   out_position_r;
  logic                 out_is_bound_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 2 logic: offset reference times reciprocal.
  logic [31:0] x_off;
  logic [63:0] prod;
  logic [SW-1:0] q_nxt;

  assign x_off = s1_ref_r ^ 32'h8000_0000;
  assign prod  = 64'(x_off) * 64'(RECIP);
  assign q_nxt = prod[32 +: SW];

  // Stage 3 logic: remainder, one correction, then shift back by 2^31.
  logic [SW-1:0]   qm_lo;
  logic [SW-1:0]   u0, t_sum, a_nxt;

  assign qm_lo   = s2_q_r * MOD_S;
  assign u0      = s2_ref_r[SW-1:0] - qm_lo;
  assign t_sum   = u0 + K_S;

  always_comb begin
    if (t_sum >= MOD2_S) begin
      a_nxt = t_sum - MOD2_S;
    end else if (t_sum >= MOD_S) begin
      a_nxt = t_sum - MOD_S;
    end else begin
      a_nxt = t_sum;
    end
  end

  // Result stage: bind path.
  logic              raw_bad, win_bad;
  logic signed [SW-1:0] b_raw, b_mod, e_off;
  logic [SW:0]       two_b;
  logic              near_lo, tie;
  logic [SW-1:0]     snap_dist;
  logic              far;
  logic signed [32:0] best_c;
  logic              bind_ovf;

  assign raw_bad = {2'b00, s3_raw_r} >= MOD_S;
  assign win_bad = (s3_win_r == 16'd0) || ($signed({2'b00, s3_win_r}) >= HALF_S);
  assign b_raw   = $signed(s3_a_r) - $signed({2'b00, s3_raw_r});
  assign b_mod   = b_raw[SW-1] ? b_raw + MODS_S : b_raw;
  assign two_b   = {b_mod, 1'b0};
  assign near_lo = two_b < {1'b0, MOD_S};
  assign tie     = two_b == {1'b0, MOD_S};
  assign e_off   = near_lo ? b_mod : b_mod - MODS_S;
  assign snap_dist = near_lo ? b_mod : MOD_S - b_mod;
  assign far     = snap_dist > {2'b00, s3_win_r};
  assign best_c  = {s3_ref_r[31], s3_ref_r} - 33'(e_off);
  assign bind_ovf = best_c[32] != best_c[31];

  // Result stage: update path.
  logic signed [SW-1:0] delta, adj;
  logic              amb;
  logic signed [32:0] next_pos;
  logic              upd_ovf;

  assign delta = $signed({2'b00, s3_raw_r}) - $signed({2'b00, last_r});
  assign amb   = (delta == HALF_S) || (delta == NHALF_S);

  always_comb begin
    if (delta > HALF_S) begin
      adj = delta - MODS_S;
    end else if (delta < NHALF_S) begin
      adj = delta + MODS_S;
    end else begin
      adj = delta;
    end
  end

  assign next_pos = {pos_r[31], pos_r} + 33'(adj);
  assign upd_ovf  = next_pos[32] != next_pos[31];

  always_comb begin
    status_nxt = mtu_pkg::ST_OK;
    bound_nxt  = bound_r;
    last_nxt   = last_r;
    pos_nxt    = pos_r;
    case (s3_func_r)
      mtu_pkg::FUNC_UPDATE: begin
        if (!bound_r) begin
          status_nxt = mtu_pkg::ST_FAR;
        end else if (raw_bad) begin
          status_nxt = mtu_pkg::ST_RANGE;
        end else if (amb) begin
          status_nxt = mtu_pkg::ST_AMBIGUOUS;
        end else if (upd_ovf) begin
          status_nxt = mtu_pkg::ST_OVERFLOW;
        end else begin
          last_nxt = s3_raw_r;
          pos_nxt  = next_pos[31:0];
        end
      end
      mtu_pkg::FUNC_BIND: begin
        if (raw_bad) begin
          status_nxt = mtu_pkg::ST_RANGE;
        end else if (win_bad) begin
          status_nxt = mtu_pkg::ST_WINDOW;
        end else if (tie) begin
          status_nxt = mtu_pkg::ST_AMBIGUOUS;
        end else if (far) begin
          status_nxt = mtu_pkg::ST_FAR;
        end else if (bind_ovf) begin
          status_nxt = mtu_pkg::ST_OVERFLOW;
        end else begin
          bound_nxt = 1'b1;
          last_nxt  = s3_raw_r;
          pos_nxt   = best_c[31:0];
        end
      end
      mtu_pkg::FUNC_UNBIND: begin
        bound_nxt = 1'b0;
      end
      default: begin
        status_nxt = mtu_pkg::ST_OK;
      end
    endcase
  end

  // Valid bits and tracker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bound_r     <= 1'b0;
      last_r      <= 16'd0;
      pos_r       <= 32'sd0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
      if (s3_v_r) begin
        bound_r <= bound_nxt;
        last_r  <= last_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r <= in_func;
      s1_raw_r  <= in_sample_raw;
      s1_ref_r  <= in_reference_position;
      s1_win_r  <= in_bind_window;

      s2_func_r <= s1_func_r;
      s2_raw_r  <= s1_raw_r;
      s2_ref_r  <= s1_ref_r;
      s2_win_r  <= s1_win_r;
      s2_q_r    <= q_nxt;

      s3_func_r <= s2_func_r;
      s3_raw_r  <= s2_raw_r;
      s3_ref_r  <= s2_ref_r;
      s3_win_r  <= s2_win_r;
      s3_a_r    <= a_nxt;

      out_status_r   <= status_nxt;
      out_position_r <= pos_nxt;
      out_is_bound_r <= bound_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_is_bound = out_is_bound_r;

  // A rejected bind or update must leave the tracker untouched.
  `MTU_ASSERT_NXT(a_err_keeps_state, clk, rst_n,
    adv && s3_v_r && (status_nxt != mtu_pkg::ST_OK),
    $stable(pos_r) && $stable(last_r) && $stable(bound_r),
    "rejected word changed tracker state")
  // A bind that succeeds leaves the tracker bound.
  `MTU_ASSERT_NXT(a_bind_sets_bound, clk, rst_n,
    adv && s3_v_r && (s3_func_r == mtu_pkg::FUNC_BIND) && (status_nxt == mtu_pkg::ST_OK),
    bound_r, "successful bind did not set bound")
  // The word on the output always reports the state it left behind.
  `MTU_ASSERT_IMP(a_out_matches_state, clk, rst_n, out_valid_r,
    (out_position_r == pos_r) && (out_is_bound_r == bound_r),
    "output word disagrees with tracker state")
  // Nothing in the last stage is dropped when the pipeline moves.
  `MTU_ASSERT_NXT(a_no_drop, clk, rst_n, adv && s3_v_r, out_valid_r,
    "result lost between last stage and output")

endmodule
